// ===== sv/ang_pkg.sv =====
`timescale 1ns / 1ps

package ang_pkg;

   // Channel count and the width of a channel index into the state arrays.
   localparam int unsigned CHANNELS = 8;
   localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // Fixed field widths.
   localparam int unsigned CH_W       = 3;
   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned PEAK_W     = 16;
   localparam int unsigned GAIN_W     = 17;
   localparam int unsigned AGE_W      = 20;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 20;
   localparam int unsigned PROD_W     = SAMPLE_W + GAIN_W + 1;

   localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'h10000;
   localparam logic [GAIN_W-1:0] GAIN_ZERO = 17'h00000;
   localparam logic [AGE_W-1:0]  AGE_MAX   = 20'hFFFFF;

   // Register reset values.
   localparam logic [15:0]     OPEN_THR_RST  = 16'd1024;
   localparam logic [15:0]     CLOSE_THR_RST = 16'd512;
   localparam logic [16:0]     ATTACK_RST    = 17'd64;
   localparam logic [16:0]     RELEASE_RST   = 17'd16;
   localparam logic [AGE_W-1:0] HOLD_RST     = 20'd480;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OPEN_THR  = 3'd0,
      REG_CLOSE_THR = 3'd1,
      REG_ATTACK    = 3'd2,
      REG_RELEASE   = 3'd3,
      REG_HOLD      = 3'd4
   } ang_reg_type;

   typedef struct packed {
      logic [PEAK_W-1:0] open_thr;
      logic [PEAK_W-1:0] close_thr;
      logic [GAIN_W-1:0] attack_step;
      logic [GAIN_W-1:0] release_step;
      logic [AGE_W-1:0]  hold_samples;
   } ang_cfg_type;

   typedef struct packed {
      logic              gate_open;
      logic [GAIN_W-1:0] gain;
   } ang_upd_type;

endpackage

// ===== sv/ang_if.sv =====
`timescale 1ns / 1ps

interface ang_req_if;
   import ang_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CH_W-1:0]            channel;
   logic signed [SAMPLE_W-1:0] sample_in;

   modport source (output valid, output channel, output sample_in, input ready);
   modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

interface ang_rsp_if;
   import ang_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CH_W-1:0]            channel_out;
   logic signed [SAMPLE_W-1:0] sample_out;
   logic                       gate_open;

   modport source (output valid, output channel_out, output sample_out, output gate_open,
                   input ready);
   modport sink   (input valid, input channel_out, input sample_out, input gate_open,
                   output ready);
endinterface

// ===== sv/ang_gain_core.sv =====
`timescale 1ns / 1ps

module ang_gain_core import ang_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  ang_cfg_type                cfg,
   input  logic                       upd_en,
   input  logic [CH_W-1:0]            channel,
   input  logic signed [SAMPLE_W-1:0] sample_in,
   output ang_upd_type                upd
);

   logic [PEAK_W-1:0] peak_ff [CHANNELS];
   logic [AGE_W-1:0]  age_ff  [CHANNELS];
   logic              open_ff [CHANNELS];
   logic [GAIN_W-1:0] gain_ff [CHANNELS];

   logic [CH_IDX_W-1:0] idx;
   logic                hit;
   logic [PEAK_W-1:0]   mag;
   logic [AGE_W-1:0]    age_inc;
   logic                replace;
   logic [PEAK_W-1:0]   peak_in;
   logic [AGE_W-1:0]    age_in;
   logic                open_in;
   logic [GAIN_W:0]     gain_sum;
   logic [GAIN_W-1:0]   gain_in;

   assign idx = CH_IDX_W'(channel);
   assign hit = 32'(channel) < CHANNELS;

   // Full-scale negative input yields 0x8000, which is the correct magnitude.
   assign mag = sample_in[SAMPLE_W-1] ? PEAK_W'(-sample_in) : PEAK_W'(sample_in);

   assign age_inc  = (age_ff[idx] != AGE_MAX) ? age_ff[idx] + 20'd1 : age_ff[idx];
   assign replace  = (mag > peak_ff[idx]) || (age_inc > cfg.hold_samples);
   assign peak_in  = replace ? mag : peak_ff[idx];
   assign age_in   = replace ? '0 : age_inc;
   assign gain_sum = {1'b0, gain_ff[idx]} + {1'b0, cfg.attack_step};

   always_comb begin
      priority if (peak_in > cfg.open_thr) begin
         open_in = 1'b1;
      end else if (peak_in < cfg.close_thr) begin
         open_in = 1'b0;
      end else begin
         open_in = open_ff[idx];
      end
   end

   always_comb begin
      if (open_in) begin
         priority if (cfg.attack_step == '0) begin
            gain_in = GAIN_ONE;
         end else if (gain_sum > {1'b0, GAIN_ONE}) begin
            gain_in = GAIN_ONE;
         end else begin
            gain_in = gain_sum[GAIN_W-1:0];
         end
      end else begin
         priority if ((cfg.release_step == '0) || (gain_ff[idx] <= cfg.release_step)) begin
            gain_in = GAIN_ZERO;
         end else begin
            gain_in = gain_ff[idx] - cfg.release_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            peak_ff[i] <= '0;
            age_ff[i]  <= '0;
            open_ff[i] <= 1'b0;
            gain_ff[i] <= '0;
         end
      end else if (upd_en && hit) begin
         peak_ff[idx] <= peak_in;
         age_ff[idx]  <= age_in;
         open_ff[idx] <= open_in;
         gain_ff[idx] <= gain_in;
      end
   end

   // A channel without state passes on a closed gate and zero gain.
   assign upd.gate_open = hit & open_in;
   assign upd.gain      = hit ? gain_in : GAIN_ZERO;

endmodule

// ===== sv/audio_noise_gate.sv =====
`timescale 1ns / 1ps

// Per-channel noise gate with peak hold, open/close hysteresis and linear Q16 gain ramps.
// It takes one sample per clock cycle unless the output stalls, on any channel in any
// order, and gives one result per sample through the input, gain and result stages, in
// the same order. The rate is set by the read-modify-write of the channel's state in the
// second stage; the third stage forms the product of sample and gain. The user writes the
// thresholds, ramp steps and hold time through the csr port only while no sample is in
// flight, which the block does not enforce; they take effect from the next sample.
module audio_noise_gate import ang_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ang_req_if.sink               req_bus,
   ang_rsp_if.source             rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   ang_cfg_type cfg_ff;
   ang_cfg_type cfg_in;

   // Input stage.
   logic                       in_v_ff;
   logic [CH_W-1:0]            in_ch_ff;
   logic signed [SAMPLE_W-1:0] in_smp_ff;

   // Gain stage.
   logic                       mid_v_ff;
   logic [CH_W-1:0]            mid_ch_ff;
   logic signed [SAMPLE_W-1:0] mid_smp_ff;
   logic [GAIN_W-1:0]          mid_gain_ff;
   logic                       mid_open_ff;

   // Result stage.
   logic                       out_v_ff;
   logic [CH_W-1:0]            out_ch_ff;
   logic signed [SAMPLE_W-1:0] out_smp_ff;
   logic                       out_open_ff;

   logic                       out_adv;
   logic                       mid_adv;
   logic                       in_adv;
   ang_upd_type                upd;
   logic signed [PROD_W-1:0]   prod;
   logic signed [SAMPLE_W-1:0] out_smp_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (ang_reg_type'(csr_index))
            REG_OPEN_THR:  cfg_in.open_thr     = PEAK_W'(csr_data);
            REG_CLOSE_THR: cfg_in.close_thr    = PEAK_W'(csr_data);
            REG_ATTACK:    cfg_in.attack_step  = GAIN_W'(csr_data);
            REG_RELEASE:   cfg_in.release_step = GAIN_W'(csr_data);
            REG_HOLD:      cfg_in.hold_samples = AGE_W'(csr_data);
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.open_thr     <= OPEN_THR_RST;
         cfg_ff.close_thr    <= CLOSE_THR_RST;
         cfg_ff.attack_step  <= ATTACK_RST;
         cfg_ff.release_step <= RELEASE_RST;
         cfg_ff.hold_samples <= HOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Each stage moves on when the one after it is empty or moving on itself.
   assign out_adv = !out_v_ff || rsp_bus.ready;
   assign mid_adv = !mid_v_ff || out_adv;
   assign in_adv  = !in_v_ff || mid_adv;
   assign req_bus.ready = in_adv;

   ang_gain_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .upd_en    (in_v_ff && mid_adv),
      .channel   (in_ch_ff),
      .sample_in (in_smp_ff),
      .upd       (upd)
   );

   // Gain is at most 1.0, so the floored product always fits the sample width.
   assign prod       = mid_smp_ff * $signed({1'b0, mid_gain_ff});
   assign out_smp_in = prod[SAMPLE_W+15:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         mid_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (in_adv) begin
            in_v_ff <= req_bus.valid;
         end
         if (mid_adv) begin
            mid_v_ff <= in_v_ff;
         end
         if (out_adv) begin
            out_v_ff <= mid_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_adv && req_bus.valid) begin
         in_ch_ff  <= req_bus.channel;
         in_smp_ff <= req_bus.sample_in;
      end
      if (mid_adv && in_v_ff) begin
         mid_ch_ff   <= in_ch_ff;
         mid_smp_ff  <= in_smp_ff;
         mid_gain_ff <= upd.gain;
         mid_open_ff <= upd.gate_open;
      end
      if (out_adv && mid_v_ff) begin
         out_ch_ff   <= mid_ch_ff;
         out_smp_ff  <= out_smp_in;
         out_open_ff <= mid_open_ff;
      end
   end

   assign rsp_bus.valid       = out_v_ff;
   assign rsp_bus.channel_out = out_ch_ff;
   assign rsp_bus.sample_out  = out_smp_ff;
   assign rsp_bus.gate_open   = out_open_ff;

endmodule

// ===== sv/ang_checker.sv =====
`timescale 1ns / 1ps

module ang_checker import ang_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [CH_W-1:0]            rsp_channel,
   input logic signed [SAMPLE_W-1:0] rsp_sample,
   input logic                       rsp_open
);

   // A result beat that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat withdrawn while stalled");

   // A stalled result beat keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_channel) && $stable(rsp_sample)
                                  && $stable(rsp_open))
      else $error("result payload changed while stalled");

   // The pipeline is empty straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // A channel without state gives silence and a closed gate.
   a_no_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (32'(rsp_channel) >= CHANNELS) |-> (rsp_sample == '0) && !rsp_open)
      else $error("unknown channel produced output");

   // The input side is never blocked while the whole pipeline can drain.
   a_req_free: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled although the output is taking beats");

endmodule

bind audio_noise_gate ang_checker u_ang_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_channel (rsp_bus.channel_out),
   .rsp_sample  (rsp_bus.sample_out),
   .rsp_open    (rsp_bus.gate_open)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import ang_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd7;
   localparam int unsigned SETTLE_CYCLES = 8;

   typedef struct {
      logic [CH_W-1:0]            channel;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       gate;
   } gated_beat_type;

   logic clock;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   ang_req_if req_bus ();
   ang_rsp_if rsp_bus ();

   audio_noise_gate dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Model of the gate: register copy and per-channel state.
   ang_cfg_type       gate_cfg;
   logic [PEAK_W-1:0] held_peak  [CHANNELS];
   logic [AGE_W-1:0]  peak_age   [CHANNELS];
   logic              open_flag  [CHANNELS];
   logic [GAIN_W-1:0] gain_level [CHANNELS];

   gated_beat_type pending_beats[$];
   bit          loud [CHANNELS];
   bit          steady;
   int          error_count;
   int          samples_sent;
   int          beats_checked;
   int          open_beats;
   int          settings_used;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("tb: done, errors");
      $finish;
   end

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= 10)
         $display("tb: mismatch at %0t: %s", $realtime, msg);
   endtask

   task automatic reset_gate_model;
      gate_cfg.open_thr     = OPEN_THR_RST;
      gate_cfg.close_thr    = CLOSE_THR_RST;
      gate_cfg.attack_step  = ATTACK_RST;
      gate_cfg.release_step = RELEASE_RST;
      gate_cfg.hold_samples = HOLD_RST;
      for (int c = 0; c < CHANNELS; c++) begin
         held_peak[c]  = '0;
         peak_age[c]   = '0;
         open_flag[c]  = 1'b0;
         gain_level[c] = GAIN_ZERO;
      end
   endtask

   // Advances one channel of the model by one sample and returns the gated beat.
   function automatic gated_beat_type gate_sample(input logic [CH_W-1:0] ch,
                                                  input logic signed [SAMPLE_W-1:0] s);
      gated_beat_type    beat;
      int                mag;
      logic [GAIN_W:0]   raised;
      longint            prod;
      beat.channel = ch;
      beat.sample  = '0;
      beat.gate    = 1'b0;
      if (ch >= CHANNELS)
         return beat;
      mag = (s < 0) ? -int'(s) : int'(s);
      if (peak_age[ch] != AGE_MAX)
         peak_age[ch]++;
      if (mag > held_peak[ch] || peak_age[ch] > gate_cfg.hold_samples) begin
         held_peak[ch] = mag[PEAK_W-1:0];
         peak_age[ch]  = '0;
      end
      if (held_peak[ch] > gate_cfg.open_thr)
         open_flag[ch] = 1'b1;
      else if (held_peak[ch] < gate_cfg.close_thr)
         open_flag[ch] = 1'b0;
      if (open_flag[ch]) begin
         raised = gain_level[ch] + gate_cfg.attack_step;
         if (gate_cfg.attack_step == '0 || raised > GAIN_ONE)
            gain_level[ch] = GAIN_ONE;
         else
            gain_level[ch] = raised[GAIN_W-1:0];
      end else begin
         if (gate_cfg.release_step == '0 || gain_level[ch] <= gate_cfg.release_step)
            gain_level[ch] = GAIN_ZERO;
         else
            gain_level[ch] = gain_level[ch] - gate_cfg.release_step;
      end
      // An arithmetic shift of the signed product rounds towards minus infinity.
      prod = longint'(s) * longint'(gain_level[ch]);
      prod = prod >>> 16;
      beat.sample = prod[SAMPLE_W-1:0];
      beat.gate   = open_flag[ch];
      return beat;
   endfunction

   function automatic int pick_gap;
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_OPEN_THR:  gate_cfg.open_thr     = value[PEAK_W-1:0];
         REG_CLOSE_THR: gate_cfg.close_thr    = value[PEAK_W-1:0];
         REG_ATTACK:    gate_cfg.attack_step  = value[GAIN_W-1:0];
         REG_RELEASE:   gate_cfg.release_step = value[GAIN_W-1:0];
         REG_HOLD:      gate_cfg.hold_samples = value[AGE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_sample(input logic [CH_W-1:0] ch,
                              input logic signed [SAMPLE_W-1:0] s);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.channel   <= ch;
      req_bus.sample_in <= s;
      do @(posedge clock); while (!req_bus.ready);
      pending_beats.push_back(gate_sample(ch, s));
      samples_sent++;
   endtask

   // Lowers valid and waits until every beat in flight has been checked.
   task automatic drain;
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_beats.size() != 0);
   endtask

   // Loud and quiet stretches per channel, so that gates open, hold and close,
   // with some plain noise mixed in.
   task automatic send_shaped_sample;
      int unsigned ch;
      int unsigned mag;
      int unsigned lo;
      int unsigned hi;
      logic signed [SAMPLE_W-1:0] s;
      ch = $urandom_range(0, CHANNELS - 1);
      if ($urandom_range(0, 99) < 8)
         loud[ch] = !loud[ch];
      if ($urandom_range(0, 99) < 15) begin
         s = SAMPLE_W'($urandom_range(0, 16'hFFFF));
      end else begin
         if (loud[ch]) begin
            lo  = (gate_cfg.open_thr >= 32768) ? 32768 : gate_cfg.open_thr + 1;
            mag = $urandom_range(lo, 32768);
         end else begin
            hi  = (gate_cfg.close_thr == 0) ? 0 : gate_cfg.close_thr - 1;
            if (hi > 32768)
               hi = 32768;
            mag = $urandom_range(0, hi);
         end
         if (mag == 32768 || $urandom_range(0, 1) == 1)
            s = SAMPLE_W'(-int'(mag));
         else
            s = SAMPLE_W'(mag);
      end
      send_sample(CH_W'(ch), s);
   endtask

   task automatic set_random_config;
      int r;
      r = $urandom_range(0, 99);
      write_reg(REG_OPEN_THR, CSR_DATA_W'((r < 15) ? 0 : (r < 25) ? 16'hFFFF :
                $urandom_range(200, 12000)));
      r = $urandom_range(0, 99);
      write_reg(REG_CLOSE_THR, CSR_DATA_W'((r < 15) ? 0 : (r < 25) ? 32768 :
                $urandom_range(0, gate_cfg.open_thr)));
      r = $urandom_range(0, 99);
      write_reg(REG_ATTACK, CSR_DATA_W'((r < 15) ? 0 : (r < 25) ? 65536 :
                $urandom_range(1, 20000)));
      r = $urandom_range(0, 99);
      write_reg(REG_RELEASE, CSR_DATA_W'((r < 15) ? 0 : (r < 25) ? 65536 :
                $urandom_range(1, 20000)));
      r = $urandom_range(0, 99);
      write_reg(REG_HOLD, CSR_DATA_W'((r < 15) ? 0 : (r < 25) ? AGE_MAX :
                $urandom_range(1, 40)));
      settings_used++;
   endtask

   task automatic test_reset_defaults;
      send_sample(3'd0, 16'sd32767);
      send_sample(3'd7, -16'sd32768);
      send_sample(3'd0, 16'sd0);
      send_sample(3'd3, 16'sd1);
      send_sample(3'd3, -16'sd1);
      send_sample(3'd5, 16'sd700);
      drain;
   endtask

   // Zero steps jump the gain at once; a zero hold replaces the peak every sample.
   task automatic test_instant_ramps;
      write_reg(REG_ATTACK, 20'd0);
      write_reg(REG_RELEASE, 20'd0);
      write_reg(REG_HOLD, 20'd0);
      write_reg(REG_OPEN_THR, 20'd0);
      write_reg(REG_CLOSE_THR, 20'd0);
      settings_used++;
      send_sample(3'd0, 16'sd5);
      send_sample(3'd0, -16'sd32768);
      send_sample(3'd0, 16'sd0);
      send_sample(3'd1, 16'sd32767);
      send_sample(3'd1, -16'sd2);
      drain;
   endtask

   // Register values beyond their range and beyond their width, an unused index,
   // and a hold time so long that a peak never expires.
   task automatic test_register_extremes;
      write_reg(REG_OPEN_THR, 20'hFFFFF);
      write_reg(REG_CLOSE_THR, 20'h0FFFF);
      write_reg(REG_ATTACK, 20'h1FFFF);
      write_reg(REG_RELEASE, 20'hFFFFF);
      write_reg(REG_HOLD, AGE_MAX);
      write_reg(REG_SPARE, 20'h12345);
      send_sample(3'd1, 16'sd100);
      send_sample(3'd0, -16'sd32768);
      drain;
      write_reg(REG_OPEN_THR, 20'd0);
      write_reg(REG_CLOSE_THR, 20'd0);
      settings_used += 2;
      send_sample(3'd2, -16'sd1000);
      send_sample(3'd2, 16'sd3);
      send_sample(3'd6, 16'sd32767);
      drain;
   endtask

   task automatic test_pause_midstream;
      write_reg(REG_OPEN_THR, 20'hF0400);
      write_reg(REG_CLOSE_THR, CSR_DATA_W'(CLOSE_THR_RST));
      write_reg(REG_ATTACK, 20'd4096);
      write_reg(REG_RELEASE, 20'd2048);
      write_reg(REG_HOLD, 20'd6);
      settings_used++;
      repeat (20) send_shaped_sample();
      drain;
      repeat (20) send_shaped_sample();
      drain;
   endtask

   task automatic test_random_settings;
      for (int phase = 0; phase < 5; phase++) begin
         set_random_config();
         steady = (phase == 2);
         repeat (80) send_shaped_sample();
         drain;
      end
      steady = 1'b0;
   endtask

   initial begin : rsp_stall
      int stall;
      stall = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (steady)
            stall = 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 30)
               stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin : check_beat
      gated_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         beats_checked++;
         if (pending_beats.size() == 0) begin
            note_error($sformatf("unexpected beat: channel %0d sample %0d gate %0b",
                                 rsp_bus.channel_out, rsp_bus.sample_out, rsp_bus.gate_open));
         end else begin
            want = pending_beats.pop_front();
            if (rsp_bus.gate_open === 1'b1)
               open_beats++;
            if (rsp_bus.channel_out !== want.channel || rsp_bus.sample_out !== want.sample ||
                rsp_bus.gate_open !== want.gate)
               note_error($sformatf("channel %0d/%0d sample %0d/%0d gate %0b/%0b (exp/got)",
                                    want.channel, rsp_bus.channel_out, want.sample,
                                    rsp_bus.sample_out, want.gate, rsp_bus.gate_open));
         end
      end
   end

   initial begin
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= REG_OPEN_THR;
      csr_data          <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.channel   <= '0;
      req_bus.sample_in <= '0;
      steady        = 1'b0;
      error_count   = 0;
      samples_sent  = 0;
      beats_checked = 0;
      open_beats    = 0;
      settings_used = 1;
      reset_gate_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_instant_ramps();
      test_register_extremes();
      test_pause_midstream();
      test_random_settings();

      drain;
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("tb: %0d samples sent, %0d beats checked, %0d of them with the gate open",
               samples_sent, beats_checked, open_beats);
      $display("tb: %0d register settings, including instant and saturating ramps",
               settings_used);
      if (error_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
sv/ang_pkg.sv
sv/ang_if.sv
sv/ang_gain_core.sv
sv/audio_noise_gate.sv
sv/ang_checker.sv
sim/tb.sv
